FILE: hw/rtl/affine_gap_local_alignment_cell_macros.svh
// Assertion macros shared by the alignment cell RTL.
`ifndef AFFINE_GAP_LOCAL_ALIGNMENT_CELL_MACROS_SVH
`define AFFINE_GAP_LOCAL_ALIGNMENT_CELL_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define AGALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cond in one cycle implies res in the next.
`define AGALC_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error(msg);

`endif

FILE: hw/rtl/agalc_pkg.sv
// Shared types and constants of the alignment cell.
`timescale 1ns / 1ps
package agalc_pkg;

  // Item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CELL = 1'b1;

  // Configuration register indexes
  localparam logic REG_GAP_OPEN   = 1'b0;
  localparam logic REG_GAP_EXTEND = 1'b1;

  // Reset values of the penalties
  localparam logic [14:0] GAP_OPEN_RESET   = 15'd20;
  localparam logic [14:0] GAP_EXTEND_RESET = 15'd1;

  // Score used outside the sequence lengths (-1000.0 in half units)
  localparam int PAD_SCORE = -2000;

  // Per-cell control flags
  typedef struct packed {
    logic new_aln;
    logic row_start;
    logic last;
  } cell_flags_t;

endpackage

FILE: hw/rtl/agalc_front.sv
// Front end: accepts items, owns the substitution table and the column counter.
`timescale 1ns / 1ps
module agalc_front #(
  parameter int MAX_QUERY  = 256,
  parameter int ALPHABET   = 128,
  parameter int SCORE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [6:0]                    query_symbol_i,
  input  logic [6:0]                    ref_symbol_i,
  input  logic signed [15:0]            table_value_i,
  input  logic                          cell_valid_i,
  input  logic                          new_alignment_i,
  input  logic                          row_start_i,
  input  logic                          last_cell_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output logic [$clog2(MAX_QUERY)-1:0]  col_o,
  output logic signed [SCORE_BITS-1:0]  subst_o,
  output agalc_pkg::cell_flags_t        flags_o
);

  localparam int SW    = SCORE_BITS;
  localparam int XW    = (SW > 16 ? SW : 16) + 2;
  localparam int CW    = $clog2(MAX_QUERY);
  localparam int SYW   = $clog2(ALPHABET);
  localparam int DEPTH = ALPHABET * ALPHABET;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  function automatic logic signed [SW-1:0] sat_score(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Symbol reduction modulo the alphabet size, one entry per symbol code
  logic [SYW-1:0] mod_lut [128];
  for (genvar i = 0; i < 128; i++) begin : g_mod
    assign mod_lut[i] = SYW'(i % ALPHABET);
  end

  logic                  accept;
  logic [AW-1:0]         tbl_addr;
  logic signed [SW-1:0]  tbl_mem [DEPTH];
  logic signed [SW-1:0]  tbl_rd_q;
  logic                  fv_q;
  logic [CW-1:0]         col_q, col_d;
  logic [CW-1:0]         fcol_q;
  logic                  fpad_q;
  agalc_pkg::cell_flags_t fflags_q;
  logic                  rs;

  assign push_o     = fv_q;
  assign in_ready_o = !fv_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tbl_addr   = AW'(mod_lut[query_symbol_i]) * AW'(ALPHABET) + AW'(mod_lut[ref_symbol_i]);
  assign rs         = row_start_i || new_alignment_i;

  // Load entries and read for cells
  always_ff @(posedge clk_i) begin
    if (accept && op_i == agalc_pkg::OP_LOAD) begin
      tbl_mem[tbl_addr] <= sat_score(XW'(table_value_i));
    end
    if (accept && op_i == agalc_pkg::OP_CELL) begin
      tbl_rd_q <= tbl_mem[tbl_addr];
    end
  end

  // Column of this cell, wrapping at the row store depth
  always_comb begin
    col_d = col_q;
    if (accept && op_i == agalc_pkg::OP_CELL) begin
      if (rs) begin
        col_d = (CW'(0) == CW'(MAX_QUERY - 1)) ? CW'(0) : CW'(1);
      end else begin
        col_d = (col_q == CW'(MAX_QUERY - 1)) ? CW'(0) : col_q + CW'(1);
      end
    end
  end

  // Hold the accepted cell until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q  <= 1'b0;
      col_q <= '0;
    end else begin
      col_q <= col_d;
      if (accept && op_i == agalc_pkg::OP_CELL) begin
        fv_q <= 1'b1;
      end else if (push_ready_i) begin
        fv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_i == agalc_pkg::OP_CELL) begin
      fcol_q             <= rs ? CW'(0) : col_q;
      fpad_q             <= !cell_valid_i;
      fflags_q.new_aln   <= new_alignment_i;
      fflags_q.row_start <= rs;
      fflags_q.last      <= last_cell_i;
    end
  end

  assign col_o   = fcol_q;
  assign subst_o = fpad_q ? SW'(agalc_pkg::PAD_SCORE) : tbl_rd_q;
  assign flags_o = fflags_q;

endmodule

FILE: hw/rtl/agalc_queue.sv
// Two-entry queue between the front end and the cell datapath.
`timescale 1ns / 1ps
`include "affine_gap_local_alignment_cell_macros.svh"
module agalc_queue #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  output logic         push_ready_o,
  input  logic [W-1:0] data_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign data_o       = slot_q[rd_q];

  // Store items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `AGALC_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `AGALC_ASSERT(a_ptr_cnt, (cnt_q == 2'd1) == (wr_q != rd_q), "queue pointers disagree with count")

endmodule

FILE: hw/rtl/agalc_back.sv
// Cell datapath: row stores, affine-gap recurrence and the result register.
`timescale 1ns / 1ps
`include "affine_gap_local_alignment_cell_macros.svh"
module agalc_back #(
  parameter int MAX_QUERY  = 256,
  parameter int SCORE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [14:0]                  gap_open_i,
  input  logic [14:0]                  gap_extend_i,
  input  logic                         pop_valid_i,
  output logic                         pop_o,
  input  logic [$clog2(MAX_QUERY)-1:0] col_i,
  input  logic signed [SCORE_BITS-1:0] subst_i,
  input  agalc_pkg::cell_flags_t       flags_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           cell_score_o,
  output logic signed [15:0]           up_gap_score_o,
  output logic [2:0]                   direction_o,
  output logic signed [15:0]           best_score_o,
  output logic                         is_last_o
);

  localparam int SW = SCORE_BITS;
  localparam int XW = (SW > 16 ? SW : 16) + 2;
  localparam int CW = $clog2(MAX_QUERY);
  localparam logic signed [XW-1:0] SAT_HI = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

  function automatic logic signed [SW-1:0] sat_score(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  logic signed [SW-1:0]   hmem [MAX_QUERY];
  logic signed [SW-1:0]   fmem [MAX_QUERY];
  logic [MAX_QUERY-1:0]   rv_q;
  logic                   sv_q;
  logic [CW-1:0]          scol_q;
  logic signed [SW-1:0]   ssub_q;
  agalc_pkg::cell_flags_t sflags_q;
  logic signed [SW-1:0]   hrd_q, frd_q, fh_q, ff_q;
  logic                   fwd_q, zero_q;
  logic                   fire, load;
  logic signed [SW-1:0]   lh_q, le_q, dg_q, best_q;
  logic signed [SW-1:0]   lh, le, dg, up, upf, e, diag, f, mde, mfz, h, best;
  logic signed [XW-1:0]   open_x, ext_x;
  logic [2:0]             dir;
  logic                   ov_q;
  logic signed [SW-1:0]   oh_q, of_q, ob_q;
  logic [2:0]             od_q;
  logic                   ol_q;

  assign fire  = sv_q && (!ov_q || out_ready_i);
  assign load  = pop_valid_i && (!sv_q || fire);
  assign pop_o = load;

  // Read the row stores, forwarding the write of the cell that leaves
  always_ff @(posedge clk_i) begin
    if (load) begin
      hrd_q    <= hmem[col_i];
      frd_q    <= fmem[col_i];
      fh_q     <= h;
      ff_q     <= f;
      fwd_q    <= !flags_i.new_aln && fire && scol_q == col_i;
      zero_q   <= flags_i.new_aln || (fire && sflags_q.new_aln && scol_q != col_i) ||
                  (!(fire && scol_q == col_i) && !rv_q[col_i]);
      scol_q   <= col_i;
      ssub_q   <= subst_i;
      sflags_q <= flags_i;
    end
    if (fire) begin
      hmem[scol_q] <= h;
      fmem[scol_q] <= f;
    end
  end

  assign up  = zero_q ? '0 : (fwd_q ? fh_q : hrd_q);
  assign upf = zero_q ? '0 : (fwd_q ? ff_q : frd_q);

  // Affine-gap recurrence for one cell
  always_comb begin
    open_x = $signed(XW'(gap_open_i));
    ext_x  = $signed(XW'(gap_extend_i));
    lh     = sflags_q.row_start ? '0 : lh_q;
    le     = sflags_q.row_start ? '0 : le_q;
    dg     = sflags_q.row_start ? '0 : dg_q;
    e      = sat_score(XW'(le) - ext_x);
    if (sat_score(XW'(lh) - open_x) > e) begin
      e = sat_score(XW'(lh) - open_x);
    end
    diag = sat_score(XW'(dg) + XW'(ssub_q));
    f    = sat_score(XW'(upf) - ext_x);
    if (sat_score(XW'(up) - open_x) > f) begin
      f = sat_score(XW'(up) - open_x);
    end
    mde  = (diag >= e) ? diag : e;
    mfz  = (f >= 0) ? f : '0;
    h    = (mde >= mfz) ? mde : mfz;
    dir  = {diag >= e, f >= 0, mde >= mfz};
    best = sflags_q.new_aln ? '0 : best_q;
    if (h > best) begin
      best = h;
    end
  end

  // Advance stage valid, row valid bits and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q   <= 1'b0;
      ov_q   <= 1'b0;
      rv_q   <= '0;
      lh_q   <= '0;
      le_q   <= '0;
      dg_q   <= '0;
      best_q <= '0;
    end else begin
      if (load) begin
        sv_q <= 1'b1;
      end else if (fire) begin
        sv_q <= 1'b0;
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (fire) begin
        for (int i = 0; i < MAX_QUERY; i++) begin
          if (CW'(i) == scol_q) begin
            rv_q[i] <= 1'b1;
          end else if (sflags_q.new_aln) begin
            rv_q[i] <= 1'b0;
          end
        end
        lh_q   <= h;
        le_q   <= e;
        dg_q   <= up;
        best_q <= best;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      oh_q <= h;
      of_q <= f;
      od_q <= dir;
      ob_q <= best;
      ol_q <= sflags_q.last;
    end
  end

  assign out_valid_o    = ov_q;
  assign cell_score_o   = 16'(oh_q);
  assign up_gap_score_o = 16'(of_q);
  assign direction_o    = od_q;
  assign best_score_o   = 16'(ob_q);
  assign is_last_o      = ol_q;

  `AGALC_ASSERT_NEXT(a_fire_out, fire, ov_q, "finished cell did not reach the result register")
  `AGALC_ASSERT_NEXT(a_new_clear, fire && sflags_q.new_aln, $countones(rv_q) == 1,
                     "new alignment left stale row entries")
  `AGALC_ASSERT(a_best_ge, !ov_q || ob_q >= oh_q, "best score below cell score")

endmodule

FILE: hw/rtl/affine_gap_local_alignment_cell.sv
// Top level of the affine-gap local alignment cell.
`timescale 1ns / 1ps
// Computes one Smith-Waterman-Gotoh cell per compute item in row-major order and
// writes substitution table entries on load items. One item is taken every clock
// cycle unless back-pressure from the result sink holds it; a cell result passes
// through the table read register, the queue, the row-store read register and the
// recurrence into the result register. The sustained rate is set by the loop
// through the left score, left gap and row store write-back. Load items produce no
// result. Row stores hold MAX_QUERY columns and the table ALPHABET*ALPHABET entries.
module affine_gap_local_alignment_cell #(
  parameter int MAX_QUERY  = 256,
  parameter int ALPHABET   = 128,
  parameter int SCORE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [6:0]         query_symbol_i,
  input  logic [6:0]         ref_symbol_i,
  input  logic signed [15:0] table_value_i,
  input  logic               cell_valid_i,
  input  logic               new_alignment_i,
  input  logic               row_start_i,
  input  logic               last_cell_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] cell_score_o,
  output logic signed [15:0] up_gap_score_o,
  output logic [2:0]         direction_o,
  output logic signed [15:0] best_score_o,
  output logic               is_last_o
);

  localparam int CW = $clog2(MAX_QUERY);
  localparam int QW = CW + SCORE_BITS + $bits(agalc_pkg::cell_flags_t);

  logic [14:0]                gap_open_q, gap_extend_q;
  logic                       push, push_ready, pop_valid, pop;
  logic [CW-1:0]              f_col, b_col;
  logic signed [SCORE_BITS-1:0] f_sub, b_sub;
  agalc_pkg::cell_flags_t     f_flags, b_flags;
  logic [QW-1:0]              q_in, q_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_q   <= agalc_pkg::GAP_OPEN_RESET;
      gap_extend_q <= agalc_pkg::GAP_EXTEND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        agalc_pkg::REG_GAP_OPEN:   gap_open_q   <= cfg_wdata_i;
        agalc_pkg::REG_GAP_EXTEND: gap_extend_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  agalc_front #(
    .MAX_QUERY (MAX_QUERY),
    .ALPHABET  (ALPHABET),
    .SCORE_BITS(SCORE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .query_symbol_i (query_symbol_i),
    .ref_symbol_i   (ref_symbol_i),
    .table_value_i  (table_value_i),
    .cell_valid_i   (cell_valid_i),
    .new_alignment_i(new_alignment_i),
    .row_start_i    (row_start_i),
    .last_cell_i    (last_cell_i),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .col_o          (f_col),
    .subst_o        (f_sub),
    .flags_o        (f_flags)
  );

  assign q_in = {f_col, f_sub, f_flags};
  assign {b_col, b_sub, b_flags} = q_out;

  agalc_queue #(
    .W(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .data_i      (q_in),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .data_o      (q_out)
  );

  agalc_back #(
    .MAX_QUERY (MAX_QUERY),
    .SCORE_BITS(SCORE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gap_open_i    (gap_open_q),
    .gap_extend_i  (gap_extend_q),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .col_i         (b_col),
    .subst_i       (b_sub),
    .flags_i       (b_flags),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_score_o  (cell_score_o),
    .up_gap_score_o(up_gap_score_o),
    .direction_o   (direction_o),
    .best_score_o  (best_score_o),
    .is_last_o     (is_last_o)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench of the affine-gap local alignment cell.
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic signed [15:0] h;
    logic signed [15:0] f;
    logic [2:0]         dir;
    logic signed [15:0] best;
    logic               last;
  } cell_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [14:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic op_i;
  logic [6:0] query_symbol_i;
  logic [6:0] ref_symbol_i;
  logic signed [15:0] table_value_i;
  logic cell_valid_i;
  logic new_alignment_i;
  logic row_start_i;
  logic last_cell_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [15:0] cell_score_o;
  logic signed [15:0] up_gap_score_o;
  logic [2:0] direction_o;
  logic signed [15:0] best_score_o;
  logic is_last_o;

  // Mirror of the cell state
  logic signed [15:0] subst_mem [128][128];
  logic signed [15:0] row_h [256];
  logic signed [15:0] row_f [256];
  logic signed [15:0] left_h, left_e, diag_h, best_h;
  logic [7:0] col_idx;
  logic [14:0] open_pen, ext_pen;
  bit written [16384];
  logic [13:0] written_pairs [$];

  cell_result_t pending_cells [$];
  int errors;
  int items_sent;
  int idle_cycles;
  bit calm;

  affine_gap_local_alignment_cell dut (.*);

  // Clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Work out H, F, direction and best score of one accepted cell
  task automatic predict_cell(logic [6:0] q, logic [6:0] r, logic cv, logic na,
                              logic rs, logic lc);
    logic signed [15:0] subst, e, diag, up, f, mde, mfz, h;
    cell_result_t res;
    if (na) begin
      for (int i = 0; i < 256; i++) begin
        row_h[i] = '0;
        row_f[i] = '0;
      end
      best_h = '0;
      rs = 1'b1;
    end
    if (rs) begin
      left_h = '0;
      left_e = '0;
      diag_h = '0;
      col_idx = '0;
    end
    subst = cv ? subst_mem[q][r] : 16'(agalc_pkg::PAD_SCORE);
    e = sat16(longint'(left_e) - ext_pen);
    if (sat16(longint'(left_h) - open_pen) > e) e = sat16(longint'(left_h) - open_pen);
    diag = sat16(longint'(diag_h) + subst);
    up = row_h[col_idx];
    f = sat16(longint'(row_f[col_idx]) - ext_pen);
    if (sat16(longint'(up) - open_pen) > f) f = sat16(longint'(up) - open_pen);
    mde = (diag >= e) ? diag : e;
    mfz = (f >= 0) ? f : 16'sd0;
    h = (mde >= mfz) ? mde : mfz;
    res.dir = {diag >= e, f >= 0, mde >= mfz};
    if (h > best_h) best_h = h;
    diag_h = up;
    row_h[col_idx] = h;
    row_f[col_idx] = f;
    left_h = h;
    left_e = e;
    col_idx = col_idx + 8'd1;
    res.h = h;
    res.f = f;
    res.best = best_h;
    res.last = lc;
    pending_cells.push_back(res);
  endtask

  // Send one item and update the mirror when it is accepted
  task automatic send_item(logic op, logic [6:0] q, logic [6:0] r, logic signed [15:0] tv,
                           logic cv, logic na, logic rs, logic lc);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    query_symbol_i <= q;
    ref_symbol_i <= r;
    table_value_i <= tv;
    cell_valid_i <= cv;
    new_alignment_i <= na;
    row_start_i <= rs;
    last_cell_i <= lc;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    items_sent++;
    if (op == agalc_pkg::OP_LOAD) begin
      subst_mem[q][r] = tv;
      if (!written[{q, r}]) begin
        written[{q, r}] = 1'b1;
        written_pairs.push_back({q, r});
      end
    end else begin
      predict_cell(q, r, cv, na, rs, lc);
    end
  endtask

  task automatic send_load(logic [6:0] q, logic [6:0] r, logic signed [15:0] tv);
    send_item(agalc_pkg::OP_LOAD, q, r, tv, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // Cell on a table entry that has been loaded
  task automatic send_known_cell(logic na, logic rs, logic lc);
    logic [13:0] p;
    p = written_pairs[$urandom_range(written_pairs.size() - 1)];
    send_item(agalc_pkg::OP_CELL, p[13:7], p[6:0], 16'($urandom), 1'b1, na, rs, lc);
  endtask

  // Drain results and let the pipeline settle before touching registers
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_penalties(logic [14:0] open_v, logic [14:0] ext_v);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= agalc_pkg::REG_GAP_OPEN;
    cfg_wdata_i <= open_v;
    @(negedge clk_i);
    cfg_idx_i <= agalc_pkg::REG_GAP_EXTEND;
    cfg_wdata_i <= ext_v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    open_pen = open_v;
    ext_pen = ext_v;
  endtask

  // Load a few table entries with random symbols and values
  task automatic load_burst(int n);
    for (int i = 0; i < n; i++) send_load(7'($urandom), 7'($urandom), 16'($urandom));
  endtask

  // One well-formed matrix, with a little noise in the flags, stray loads and pad cells
  task automatic run_matrix(int rows, int cols);
    logic na, rs, cv;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        na = (y == 0 && x == 0);
        rs = (x == 0) && !(na && $urandom_range(3) == 0);
        if ($urandom_range(99) < 3) begin
          na = 1'($urandom);
          rs = 1'($urandom);
        end
        if ($urandom_range(99) < 3) load_burst(1);
        cv = $urandom_range(9) != 0;
        if (cv) send_known_cell(na, rs, y == rows - 1 && x == cols - 1);
        else send_item(agalc_pkg::OP_CELL, 7'($urandom), 7'($urandom), 16'($urandom), 1'b0,
                       na, rs, y == rows - 1 && x == cols - 1);
      end
    end
  endtask

  // Table extremes, pad score, flags and the reset penalties
  task automatic test_directed();
    send_load(7'd0, 7'd0, -16'sd32768);
    send_load(7'd127, 7'd127, 16'sd32767);
    send_load(7'd3, 7'd5, 16'sd10);
    send_load(7'd5, 7'd3, -16'sd4);
    send_item(agalc_pkg::OP_CELL, 7'd3, 7'd5, '0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd127, 7'd127, '0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd0, 7'd0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd5, 7'd3, '0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd127, 7'd127, '0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd42, 7'd99, '0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd0, 7'd0, '0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd3, 7'd5, '0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(agalc_pkg::OP_CELL, 7'd127, 7'd0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_item(agalc_pkg::OP_CELL, 7'd3, 7'd5, '0, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  // Rows longer than the row store wrap to column zero
  task automatic test_long_row();
    calm = 1'b1;
    run_matrix(2, 300);
    calm = 1'b0;
  endtask

  // Random matrices under several penalty settings, extremes included
  task automatic test_penalty_sweep();
    logic [14:0] opens [5] = '{15'd0, 15'd32767, 15'd4, 15'd20, 15'd0};
    logic [14:0] exts  [5] = '{15'd0, 15'd32767, 15'd1, 15'd1, 15'd32767};
    int base;
    base = items_sent;
    for (int s = 0; s < 6; s++) begin
      if (s < 5) write_penalties(opens[s], exts[s]);
      else write_penalties(15'($urandom), 15'($urandom));
      load_burst(8);
      while (items_sent < base + 100 * (s + 1)) begin
        calm = $urandom_range(4) == 0;
        if ($urandom_range(9) == 0) run_matrix($urandom_range(3, 1), $urandom_range(40, 20));
        else run_matrix($urandom_range(6, 1), $urandom_range(12, 1));
      end
      calm = 1'b0;
    end
  endtask

  // Result sink ready, with random stalls
  always @(negedge clk_i) begin
    int stall;
    if (!calm && $urandom_range(99) < 30) begin
      out_ready_i <= 1'b0;
      stall = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      repeat (stall - 1) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    cell_result_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: result with none expected: H %0d", $realtime, cell_score_o);
        errors++;
      end else begin
        exp_c = pending_cells.pop_front();
        if (cell_score_o !== exp_c.h) begin
          $display("%0t: cell_score expected %0d actual %0d", $realtime, exp_c.h, cell_score_o);
          errors++;
        end
        if (up_gap_score_o !== exp_c.f) begin
          $display("%0t: up_gap_score expected %0d actual %0d", $realtime, exp_c.f,
                   up_gap_score_o);
          errors++;
        end
        if (direction_o !== exp_c.dir) begin
          $display("%0t: direction expected %0d actual %0d", $realtime, exp_c.dir, direction_o);
          errors++;
        end
        if (best_score_o !== exp_c.best) begin
          $display("%0t: best_score expected %0d actual %0d", $realtime, exp_c.best,
                   best_score_o);
          errors++;
        end
        if (is_last_o !== exp_c.last) begin
          $display("%0t: is_last expected %0d actual %0d", $realtime, exp_c.last, is_last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = agalc_pkg::REG_GAP_OPEN;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    op_i = agalc_pkg::OP_LOAD;
    query_symbol_i = '0;
    ref_symbol_i = '0;
    table_value_i = '0;
    cell_valid_i = 1'b0;
    new_alignment_i = 1'b0;
    row_start_i = 1'b0;
    last_cell_i = 1'b0;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    calm = 1'b0;
    for (int i = 0; i < 256; i++) begin
      row_h[i] = '0;
      row_f[i] = '0;
    end
    left_h = '0;
    left_e = '0;
    diag_h = '0;
    best_h = '0;
    col_idx = '0;
    open_pen = agalc_pkg::GAP_OPEN_RESET;
    ext_pen = agalc_pkg::GAP_EXTEND_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_long_row();
    test_penalty_sweep();
    wait_idle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/agalc_pkg.sv
hw/rtl/agalc_front.sv
hw/rtl/agalc_queue.sv
hw/rtl/agalc_back.sv
hw/rtl/affine_gap_local_alignment_cell.sv
sim/testbench.sv
